@@ rtl/obfc_pkg.sv @@
package obfc_pkg;

    localparam int POS_W       = 21;
    localparam int DIR_W       = 16;
    localparam int OFS_W       = 32;
    localparam int FRAC_SHIFT  = 14;
    localparam int PROD_W      = POS_W + DIR_W;
    localparam int ACC_W       = PROD_W + 3;
    localparam int DOT_W       = PROD_W + 2;
    localparam int CMP_W       = OFS_W + FRAC_SHIFT + 1;
    localparam int BOX_CORNERS = 8;
    localparam int NUM_CORNERS = 8;
    localparam int NUM_PLANES_DEF = 6;

    localparam logic [1:0] CMD_LOAD_PLANE  = 2'd0;
    localparam logic [1:0] CMD_LOAD_CORNER = 2'd1;
    localparam logic [1:0] CMD_TEST        = 2'd2;

    localparam logic [1:0] REASON_NONE  = 2'd0;
    localparam logic [1:0] REASON_PLANE = 2'd1;
    localparam logic [1:0] REASON_FACE  = 2'd2;

    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic signed [DIR_W-1:0] dir_t;

    function automatic pos_t pos_f(input logic [3*POS_W-1:0] v, input int idx);
        return pos_t'(v[idx*POS_W +: POS_W]);
    endfunction

    function automatic dir_t dir_f(input logic [3*DIR_W-1:0] v, input int idx);
        return dir_t'(v[idx*DIR_W +: DIR_W]);
    endfunction

endpackage

@@ rtl/obfc_box_corners.sv @@
module obfc_box_corners import obfc_pkg::*; (
    input  logic                 aclk,
    input  logic                 en1,
    input  logic                 en2,
    input  logic [3*POS_W-1:0]   center,
    input  logic [3*POS_W-1:0]   half_size,
    input  logic [3*DIR_W-1:0]   axes [3],
    output pos_t                 corners [BOX_CORNERS][3]
);

    logic signed [PROD_W-1:0] prod_reg [3][3];
    pos_t                     ctr_reg  [3];
    pos_t                     corner_reg  [BOX_CORNERS][3];
    pos_t                     corner_next [BOX_CORNERS][3];

    always_ff @(posedge aclk) begin
        if (en1) begin
            for (int ax = 0; ax < 3; ax++) begin
                ctr_reg[ax] <= pos_f(center, ax);
                for (int k = 0; k < 3; k++) begin
                    prod_reg[ax][k] <= PROD_W'(pos_f(half_size, ax)) *
                                       PROD_W'(dir_f(axes[ax], k));
                end
            end
        end
    end

    // Sum in Q.18, round half up, floor shift back to Q.4 and saturate.
    always_comb begin
        logic signed [ACC_W-1:0]            acc;
        logic signed [ACC_W-FRAC_SHIFT-1:0] sh;
        for (int i = 0; i < BOX_CORNERS; i++) begin
            for (int k = 0; k < 3; k++) begin
                acc = ACC_W'($signed({ctr_reg[k], {FRAC_SHIFT{1'b0}}}));
                for (int ax = 0; ax < 3; ax++) begin
                    if (((i >> (2 - ax)) & 1) != 0) begin
                        acc = acc + ACC_W'(prod_reg[ax][k]);
                    end else begin
                        acc = acc - ACC_W'(prod_reg[ax][k]);
                    end
                end
                acc = acc + (ACC_W'(1) <<< (FRAC_SHIFT - 1));
                sh  = (ACC_W-FRAC_SHIFT)'(acc >>> FRAC_SHIFT);
                if (sh > (ACC_W-FRAC_SHIFT)'((1 <<< (POS_W - 1)) - 1)) begin
                    corner_next[i][k] = pos_t'((1 <<< (POS_W - 1)) - 1);
                end else if (sh < -(ACC_W-FRAC_SHIFT)'(1 <<< (POS_W - 1))) begin
                    corner_next[i][k] = pos_t'(-(1 <<< (POS_W - 1)));
                end else begin
                    corner_next[i][k] = pos_t'(sh);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            corner_reg <= corner_next;
        end
    end

    assign corners = corner_reg;

endmodule

@@ rtl/obfc_cull_eval.sv @@
module obfc_cull_eval import obfc_pkg::*; #(
    parameter int NUM_PLANES = NUM_PLANES_DEF
) (
    input  logic                      aclk,
    input  logic                      en3,
    input  logic                      en4,
    input  pos_t                      corners [BOX_CORNERS][3],
    input  logic [3*DIR_W-1:0]        normals [NUM_PLANES],
    input  logic signed [OFS_W-1:0]   offsets [NUM_PLANES],
    input  logic [3*POS_W-1:0]        fcorners [NUM_CORNERS],
    input  logic [3*POS_W-1:0]        box_min,
    input  logic [3*POS_W-1:0]        box_max,
    output logic [NUM_PLANES-1:0]     plane_rej,
    output logic                      face_rej
);

    logic signed [PROD_W-1:0] dprod_reg [NUM_PLANES][BOX_CORNERS][3];
    logic signed [CMP_W-1:0]  dref_reg  [NUM_PLANES];
    logic                     face3_reg;
    logic                     face_next;
    logic [NUM_PLANES-1:0]    plane_rej_reg;
    logic [NUM_PLANES-1:0]    plane_rej_next;
    logic                     face_rej_reg;

    always_comb begin
        logic above;
        logic below;
        face_next = 1'b0;
        for (int k = 0; k < 3; k++) begin
            above = 1'b1;
            below = 1'b1;
            for (int i = 0; i < NUM_CORNERS; i++) begin
                if (!(pos_f(fcorners[i], k) > pos_f(box_max, k))) above = 1'b0;
                if (!(pos_f(fcorners[i], k) < pos_f(box_min, k))) below = 1'b0;
            end
            if (above || below) face_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            face3_reg <= face_next;
            for (int p = 0; p < NUM_PLANES; p++) begin
                dref_reg[p] <= CMP_W'($signed({offsets[p], {FRAC_SHIFT{1'b0}}}));
                for (int i = 0; i < BOX_CORNERS; i++) begin
                    for (int k = 0; k < 3; k++) begin
                        dprod_reg[p][i][k] <= PROD_W'(dir_f(normals[p], k)) *
                                              PROD_W'(corners[i][k]);
                    end
                end
            end
        end
    end

    always_comb begin
        logic signed [DOT_W-1:0] dot;
        for (int p = 0; p < NUM_PLANES; p++) begin
            plane_rej_next[p] = 1'b1;
            for (int i = 0; i < BOX_CORNERS; i++) begin
                dot = DOT_W'(dprod_reg[p][i][0]) + DOT_W'(dprod_reg[p][i][1]) +
                      DOT_W'(dprod_reg[p][i][2]);
                if (!(CMP_W'(dot) > dref_reg[p])) plane_rej_next[p] = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            plane_rej_reg <= plane_rej_next;
            face_rej_reg  <= face3_reg;
        end
    end

    assign plane_rej = plane_rej_reg;
    assign face_rej  = face_rej_reg;

endmodule

@@ rtl/oriented_box_frustum_cull.sv @@
// Each test beat passes through every pipeline stage and then the output register.
// Throughput: one beat per cycle while m_ready is high; every stage holds one item
// and moves on when the next stage has room, so a full pipeline streams one test box
// per cycle. Load beats are accepted at the same rate and give no result beat.
// Reset (aresetn low, synchronous) empties the pipeline and clears all planes
// and frustum corners to zero.
module oriented_box_frustum_cull import obfc_pkg::*; #(
    parameter int NUM_PLANES = NUM_PLANES_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_command,
    input  logic [2:0]              s_slot,
    input  logic [62:0]             s_center,
    input  logic [62:0]             s_half_size,
    input  logic [47:0]             s_axis_first,
    input  logic [47:0]             s_axis_second,
    input  logic [47:0]             s_axis_third,
    input  logic [62:0]             s_box_min,
    input  logic [62:0]             s_box_max,
    input  logic [47:0]             s_plane_normal,
    input  logic signed [31:0]      s_plane_offset,
    input  logic [62:0]             s_corner_point,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_visible,
    output logic [1:0]              m_reject_reason
);

    // Pipeline map:
    //   stage 1: half size times axis products.
    //   stage 2: the eight box corners, rounded and saturated.
    //   stage 3: plane normal times corner products, plus the aligned box face test.
    //   stage 4: dot product sums compared with each plane offset.
    //   output: reason encoding, held until the result beat is taken.
    // Load beats travel with the test beats through stages 1 and 2 and write the
    // plane and corner registers as they leave stage 2. Stage 3 is where those
    // registers are read, so every test sees exactly the loads that came before it.

    logic        v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    logic        en1, en2, en3, en4, en_out, leave2;

    logic [1:0]  cmd1_reg, cmd2_reg;
    logic [2:0]  slot1_reg, slot2_reg;
    logic [62:0] bmin1_reg, bmin2_reg, bmax1_reg, bmax2_reg;
    logic [47:0] pn1_reg, pn2_reg;
    logic signed [31:0] po1_reg, po2_reg;
    logic [62:0] cp1_reg, cp2_reg;

    logic [3*DIR_W-1:0]      normal_reg [NUM_PLANES];
    logic signed [OFS_W-1:0] offset_reg [NUM_PLANES];
    logic [3*POS_W-1:0]      fcorner_reg [NUM_CORNERS];

    logic [3*DIR_W-1:0]      axes [3];
    pos_t                    corners [BOX_CORNERS][3];
    logic [NUM_PLANES-1:0]   plane_rej;
    logic                    face_rej;
    logic [1:0]              reason_reg;

    assign axes[0] = s_axis_first;
    assign axes[1] = s_axis_second;
    assign axes[2] = s_axis_third;

    // Handshake chain, computed from the output back to the input. A beat
    // that is not a test leaves stage 2 at once and never blocks.
    assign en_out = v4_reg && (!vo_reg || m_ready);
    assign en4    = v3_reg && (!v4_reg || en_out);
    assign leave2 = v2_reg && ((cmd2_reg != CMD_TEST) || !v3_reg || en4);
    assign en3    = leave2 && (cmd2_reg == CMD_TEST);
    assign en2    = v1_reg && (!v2_reg || leave2);
    assign s_ready = !v1_reg || en2;
    assign en1    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= 1'b1; else if (en2) v1_reg <= 1'b0;
            if (en2) v2_reg <= 1'b1; else if (leave2) v2_reg <= 1'b0;
            if (en3) v3_reg <= 1'b1; else if (en4) v3_reg <= 1'b0;
            if (en4) v4_reg <= 1'b1; else if (en_out) v4_reg <= 1'b0;
            if (en_out) vo_reg <= 1'b1; else if (m_ready) vo_reg <= 1'b0;
        end
    end

    // Side payload that rides along with the arithmetic of stages 1 and 2.
    always_ff @(posedge aclk) begin
        if (en1) begin
            cmd1_reg  <= s_command;
            slot1_reg <= s_slot;
            bmin1_reg <= s_box_min;
            bmax1_reg <= s_box_max;
            pn1_reg   <= s_plane_normal;
            po1_reg   <= s_plane_offset;
            cp1_reg   <= s_corner_point;
        end
        if (en2) begin
            cmd2_reg  <= cmd1_reg;
            slot2_reg <= slot1_reg;
            bmin2_reg <= bmin1_reg;
            bmax2_reg <= bmax1_reg;
            pn2_reg   <= pn1_reg;
            po2_reg   <= po1_reg;
            cp2_reg   <= cp1_reg;
        end
    end

    // Plane and corner stores. A plane load to a slot beyond the plane count
    // matches no entry and is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                normal_reg[p] <= '0;
                offset_reg[p] <= '0;
            end
            for (int i = 0; i < NUM_CORNERS; i++) begin
                fcorner_reg[i] <= '0;
            end
        end else if (leave2) begin
            if (cmd2_reg == CMD_LOAD_PLANE) begin
                for (int p = 0; p < NUM_PLANES; p++) begin
                    if (slot2_reg == 3'(p)) begin
                        normal_reg[p] <= pn2_reg;
                        offset_reg[p] <= po2_reg;
                    end
                end
            end else if (cmd2_reg == CMD_LOAD_CORNER) begin
                fcorner_reg[slot2_reg] <= cp2_reg;
            end
        end
    end

    obfc_box_corners u_box_corners (
        .aclk      (aclk),
        .en1       (en1),
        .en2       (en2),
        .center    (s_center),
        .half_size (s_half_size),
        .axes      (axes),
        .corners   (corners)
    );

    obfc_cull_eval #(
        .NUM_PLANES (NUM_PLANES)
    ) u_cull_eval (
        .aclk      (aclk),
        .en3       (en3),
        .en4       (en4),
        .corners   (corners),
        .normals   (normal_reg),
        .offsets   (offset_reg),
        .fcorners  (fcorner_reg),
        .box_min   (bmin2_reg),
        .box_max   (bmax2_reg),
        .plane_rej (plane_rej),
        .face_rej  (face_rej)
    );

    // Plane rejection takes precedence over the face test.
    always_ff @(posedge aclk) begin
        if (en_out) begin
            if (|plane_rej) begin
                reason_reg <= REASON_PLANE;
            end else if (face_rej) begin
                reason_reg <= REASON_FACE;
            end else begin
                reason_reg <= REASON_NONE;
            end
        end
    end

    assign m_valid         = vo_reg;
    assign m_reject_reason = reason_reg;
    assign m_visible       = (reason_reg == REASON_NONE);

    a_stage3_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && !en4) |=> v3_reg)
        else $error("stage 3 item lost during stall");

    a_only_tests_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        en3 |-> (v2_reg && cmd2_reg == CMD_TEST))
        else $error("non-test beat entered stage 3");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && !v1_reg && !v4_reg))
        else $error("pipeline not empty after reset");

    a_reason_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_reject_reason == REASON_NONE || m_reject_reason == REASON_PLANE ||
                     m_reject_reason == REASON_FACE))
        else $error("unknown reject reason");

endmodule

@@ verif/oriented_box_frustum_cull_tb.sv @@
module oriented_box_frustum_cull_tb import obfc_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PLANES = NUM_PLANES_DEF;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 40;

    // Result beat as predicted for one test beat.
    typedef struct packed {
        logic       visible;
        logic [1:0] reason;
    } verdict_t;

    // One input beat, all fields.
    typedef struct {
        logic [1:0]         command;
        logic [2:0]         slot;
        logic [62:0]        center;
        logic [62:0]        half_size;
        logic [47:0]        axis_first;
        logic [47:0]        axis_second;
        logic [47:0]        axis_third;
        logic [62:0]        box_min;
        logic [62:0]        box_max;
        logic [47:0]        plane_normal;
        logic signed [31:0] plane_offset;
        logic [62:0]        corner_point;
    } beat_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_command = '0;
    logic [2:0]         s_slot = '0;
    logic [62:0]        s_center = '0;
    logic [62:0]        s_half_size = '0;
    logic [47:0]        s_axis_first = '0;
    logic [47:0]        s_axis_second = '0;
    logic [47:0]        s_axis_third = '0;
    logic [62:0]        s_box_min = '0;
    logic [62:0]        s_box_max = '0;
    logic [47:0]        s_plane_normal = '0;
    logic signed [31:0] s_plane_offset = '0;
    logic [62:0]        s_corner_point = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_visible;
    logic [1:0]         m_reject_reason;

    oriented_box_frustum_cull dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_command(s_command), .s_slot(s_slot),
        .s_center(s_center), .s_half_size(s_half_size),
        .s_axis_first(s_axis_first), .s_axis_second(s_axis_second),
        .s_axis_third(s_axis_third),
        .s_box_min(s_box_min), .s_box_max(s_box_max),
        .s_plane_normal(s_plane_normal), .s_plane_offset(s_plane_offset),
        .s_corner_point(s_corner_point),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_visible(m_visible), .m_reject_reason(m_reject_reason)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // The predictor's own copy of the plane and corner stores.
    logic [47:0]        pred_normal [PLANES];
    logic signed [31:0] pred_offset [PLANES];
    logic [62:0]        pred_corner [NUM_CORNERS];

    verdict_t pending_verdicts [$];
    int       mismatch_count = 0;
    int       idle_cycles = 0;
    int       sent_beats = 0;

    // Controls how hard the sender and receiver throttle; a value of zero turns
    // throttling off so that the pipeline is also exercised at full rate.
    int       send_gap_max = 3;
    int       stall_pct = 30;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    function automatic logic signed [20:0] pos_field(input logic [62:0] v, input int k);
        return v[k*21 +: 21];
    endfunction

    function automatic logic signed [15:0] dir_field(input logic [47:0] v, input int k);
        return v[k*16 +: 16];
    endfunction

    // Rounds a Q.18 value to Q.4 (round half up, floor shift) and saturates to
    // the signed 21-bit position range.
    function automatic logic signed [20:0] round_to_pos(input logic signed [63:0] acc);
        logic signed [63:0] r;
        r = (acc + 64'sd8192) >>> 14;
        if (r > 64'sd1048575) return 21'sh0FFFFF;
        if (r < -64'sd1048576) return 21'sh100000;
        return r[20:0];
    endfunction

    // Works out the cull verdict of one test beat against the current stores.
    function automatic verdict_t cull_verdict(input beat_t b);
        logic signed [63:0] pts [8][3];
        logic signed [63:0] acc, t, dot, d;
        logic signed [63:0] v;
        logic [1:0] reason;
        int cnt, above, below;
        reason = REASON_NONE;
        for (int i = 0; i < 8; i++) begin
            for (int k = 0; k < 3; k++) begin
                acc = 64'(pos_field(b.center, k)) <<< 14;
                for (int ax = 0; ax < 3; ax++) begin
                    case (ax)
                        0: t = 64'(pos_field(b.half_size, 0)) * 64'(dir_field(b.axis_first, k));
                        1: t = 64'(pos_field(b.half_size, 1)) * 64'(dir_field(b.axis_second, k));
                        default: t = 64'(pos_field(b.half_size, 2))
                                     * 64'(dir_field(b.axis_third, k));
                    endcase
                    if ((i >> (2 - ax)) & 1) acc = acc + t;
                    else acc = acc - t;
                end
                pts[i][k] = 64'(round_to_pos(acc));
            end
        end
        // Planes in index order first.
        for (int p = 0; p < PLANES && reason == REASON_NONE; p++) begin
            d = 64'(pred_offset[p]) <<< 14;
            cnt = 0;
            for (int i = 0; i < 8; i++) begin
                dot = 64'(dir_field(pred_normal[p], 0)) * pts[i][0]
                    + 64'(dir_field(pred_normal[p], 1)) * pts[i][1]
                    + 64'(dir_field(pred_normal[p], 2)) * pts[i][2];
                if (dot - d > 0) cnt++;
            end
            if (cnt == 8) reason = REASON_PLANE;
        end
        // Then the aligned box faces, axis by axis.
        for (int k = 0; k < 3 && reason == REASON_NONE; k++) begin
            above = 0;
            below = 0;
            for (int i = 0; i < NUM_CORNERS; i++) begin
                v = 64'(pos_field(pred_corner[i], k));
                if (v > 64'(pos_field(b.box_max, k))) above++;
                if (v < 64'(pos_field(b.box_min, k))) below++;
            end
            if (above == NUM_CORNERS || below == NUM_CORNERS) reason = REASON_FACE;
        end
        return '{visible: (reason == REASON_NONE), reason: reason};
    endfunction

    // Applies one accepted beat to the predictor.
    function automatic void predict_beat(input beat_t b);
        case (b.command)
            CMD_LOAD_PLANE: begin
                if (b.slot < PLANES) begin
                    pred_normal[b.slot] = b.plane_normal;
                    pred_offset[b.slot] = b.plane_offset;
                end
            end
            CMD_LOAD_CORNER: pred_corner[b.slot] = b.corner_point;
            CMD_TEST: pending_verdicts.push_back(cull_verdict(b));
            default: ;
        endcase
    endfunction

    // Sends one beat: drives it at a rising edge, holds it until accepted, and
    // then waits out a random gap (the burst pattern comes from send_gap_max).
    task automatic send_beat(input beat_t b);
        int gap;
        s_valid        <= 1'b1;
        s_command      <= b.command;
        s_slot         <= b.slot;
        s_center       <= b.center;
        s_half_size    <= b.half_size;
        s_axis_first   <= b.axis_first;
        s_axis_second  <= b.axis_second;
        s_axis_third   <= b.axis_third;
        s_box_min      <= b.box_min;
        s_box_max      <= b.box_max;
        s_plane_normal <= b.plane_normal;
        s_plane_offset <= b.plane_offset;
        s_corner_point <= b.corner_point;
        do @(posedge aclk); while (!s_ready);
        predict_beat(b);
        sent_beats++;
        // Bursts: most beats follow back to back, some leave a gap.
        gap = ($urandom_range(99) < 70) ? 0 : $urandom_range(send_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Lowers valid once the stream of beats is over.
    task automatic end_stream();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Waits until every expected verdict has come back, then lets the pipeline
    // settle for its latency before the stores change again.
    task automatic drain();
        end_stream();
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Receiver stall pattern: runs of ready and of stall of random length.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_pct == 0) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Checks each result beat against the oldest pending verdict.
    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("unexpected result beat", 1, 0);
            end else begin
                want = pending_verdicts.pop_front();
                if (m_visible !== want.visible)
                    report_mismatch("visible", m_visible, want.visible);
                if (m_reject_reason !== want.reason)
                    report_mismatch("reject_reason", m_reject_reason, want.reason);
            end
        end
    end

    // Watchdog: counts cycles with no beat accepted on either side.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("oriented_box_frustum_cull_tb failed");
            $finish;
        end
    end

    function automatic beat_t blank_beat(input logic [1:0] cmd);
        beat_t b;
        b.command = cmd;
        b.slot = '0;
        b.center = '0;
        b.half_size = '0;
        b.axis_first = '0;
        b.axis_second = '0;
        b.axis_third = '0;
        b.box_min = '0;
        b.box_max = '0;
        b.plane_normal = '0;
        b.plane_offset = '0;
        b.corner_point = '0;
        return b;
    endfunction

    function automatic logic [62:0] rand63();
        return 63'({$urandom(), $urandom()});
    endfunction

    function automatic logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    function automatic logic [62:0] pack_pos(input int x, input int y, input int z);
        logic [20:0] px, py, pz;
        px = 21'(x);
        py = 21'(y);
        pz = 21'(z);
        return {pz, py, px};
    endfunction

    function automatic logic [47:0] pack_dir(input int x, input int y, input int z);
        logic [15:0] dx, dy, dz;
        dx = 16'(x);
        dy = 16'(y);
        dz = 16'(z);
        return {dz, dy, dx};
    endfunction

    // A small position, so that boxes and the frustum overlap often enough
    // for every verdict to occur.
    function automatic int small_pos();
        return $signed($urandom_range(2048)) - 1024;
    endfunction

    task automatic load_plane(input int slot, input logic [47:0] n, input logic [31:0] d);
        beat_t b;
        b = blank_beat(CMD_LOAD_PLANE);
        b.slot = 3'(slot);
        b.plane_normal = n;
        b.plane_offset = d;
        b.center = rand63();   // unused fields carry noise
        send_beat(b);
    endtask

    task automatic load_corner(input int slot, input logic [62:0] p);
        beat_t b;
        b = blank_beat(CMD_LOAD_CORNER);
        b.slot = 3'(slot);
        b.corner_point = p;
        b.plane_normal = rand48();
        send_beat(b);
    endtask

    task automatic test_box(input logic [62:0] c, input logic [62:0] r,
                            input logic [47:0] a0, input logic [47:0] a1,
                            input logic [47:0] a2, input logic [62:0] lo,
                            input logic [62:0] hi);
        beat_t b;
        b = blank_beat(CMD_TEST);
        b.slot = 3'($urandom_range(7));
        b.center = c;
        b.half_size = r;
        b.axis_first = a0;
        b.axis_second = a1;
        b.axis_third = a2;
        b.box_min = lo;
        b.box_max = hi;
        b.corner_point = rand63();
        send_beat(b);
    endtask

    // A box with random content near the origin, unit-like axes.
    task automatic random_box();
        int cx, cy, cz;
        cx = small_pos();
        cy = small_pos();
        cz = small_pos();
        test_box(pack_pos(cx, cy, cz),
                 pack_pos($urandom_range(200), $urandom_range(200), $urandom_range(200)),
                 pack_dir(16384, 0, 0), pack_dir(0, 16384, 0), pack_dir(0, 0, 16384),
                 pack_pos(cx - 150, cy - 150, cz - 150),
                 pack_pos(cx + 150, cy + 150, cz + 150));
    endtask

    // Loads a sensible frustum: a cube of planes around the origin and its
    // eight corners, with the given extent.
    task automatic load_cube_frustum(input int ext);
        load_plane(0, pack_dir(16384, 0, 0), ext);
        load_plane(1, pack_dir(-16384, 0, 0), ext);
        load_plane(2, pack_dir(0, 16384, 0), ext);
        load_plane(3, pack_dir(0, -16384, 0), ext);
        load_plane(4, pack_dir(0, 0, 16384), ext);
        load_plane(5, pack_dir(0, 0, -16384), ext);
        for (int i = 0; i < NUM_CORNERS; i++)
            load_corner(i, pack_pos((i & 4) ? ext : -ext, (i & 2) ? ext : -ext,
                                    (i & 1) ? ext : -ext));
    endtask

    // Directed: with empty stores no plane rejects a box; extremes saturate;
    // unused command and out-of-range plane slot are ignored; then each
    // verdict through a cube frustum, an inverted box and negative sizes.
    task automatic test_directed();
        beat_t b;
        test_box('0, '0, '0, '0, '0, '0, '0);
        test_box({63{1'b1}}, {63{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}},
                 {63{1'b1}}, {63{1'b1}});
        test_box(pack_pos(1048575, -1048576, 1048575),
                 pack_pos(1048575, 1048575, -1048576),
                 pack_dir(32767, -32768, 32767), pack_dir(-32768, 32767, -32768),
                 pack_dir(32767, 32767, 32767), pack_pos(-1048576, -1048576, -1048576),
                 pack_pos(1048575, 1048575, 1048575));
        b = blank_beat(2'd3);
        b.center = rand63();
        send_beat(b);
        load_plane(6, pack_dir(16384, 0, 0), -100);
        load_plane(7, pack_dir(-16384, 0, 0), 32'h8000_0000);
        test_box('0, pack_pos(10, 10, 10), pack_dir(16384, 0, 0), pack_dir(0, 16384, 0),
                 pack_dir(0, 0, 16384), pack_pos(-10, -10, -10), pack_pos(10, 10, 10));
        drain();
        load_cube_frustum(500);
        // Inside, beyond plane 1, beyond a face only, inverted box, negative sizes.
        test_box('0, pack_pos(16, 16, 16), pack_dir(16384, 0, 0), pack_dir(0, 16384, 0),
                 pack_dir(0, 0, 16384), pack_pos(-16, -16, -16), pack_pos(16, 16, 16));
        test_box(pack_pos(-2000, 0, 0), pack_pos(16, 16, 16), pack_dir(16384, 0, 0),
                 pack_dir(0, 16384, 0), pack_dir(0, 0, 16384),
                 pack_pos(-2016, -16, -16), pack_pos(-1984, 16, 16));
        test_box('0, pack_pos(16, 16, 16), pack_dir(16384, 0, 0), pack_dir(0, 16384, 0),
                 pack_dir(0, 0, 16384), pack_pos(600, -16, -16), pack_pos(700, 16, 16));
        test_box('0, pack_pos(16, 16, 16), pack_dir(16384, 0, 0), pack_dir(0, 16384, 0),
                 pack_dir(0, 0, 16384), pack_pos(16, 16, 16), pack_pos(-16, -16, -16));
        test_box('0, pack_pos(-16, -16, -16), pack_dir(16384, 0, 0),
                 pack_dir(0, 16384, 0), pack_dir(0, 0, 16384),
                 pack_pos(-16, -16, 600), pack_pos(16, 16, 700));
        drain();
    endtask

    // Random: mostly sensible frusta with random boxes, some fully random
    // loads and boxes, and throttling that varies from phase to phase.
    task automatic test_random();
        int r;
        for (int phase = 0; phase < 8; phase++) begin
            send_gap_max = (phase % 3 == 0) ? 0 : $urandom_range(6);
            stall_pct = (phase % 4 == 1) ? 0 : $urandom_range(70);
            load_cube_frustum($urandom_range(1500) + 50);
            for (int n = 0; n < 140; n++) begin
                r = $urandom_range(99);
                if (r < 70) random_box();
                else if (r < 80)
                    test_box(rand63(), rand63(), rand48(), rand48(), rand48(),
                             rand63(), rand63());
                else if (r < 88)
                    load_plane($urandom_range(7), rand48(), $urandom());
                else if (r < 95)
                    load_corner($urandom_range(7),
                                pack_pos(small_pos(), small_pos(), small_pos()));
                else begin
                    beat_t b;
                    b = blank_beat(2'($urandom_range(3)));
                    b.slot = 3'($urandom_range(7));
                    b.center = rand63();
                    b.half_size = rand63();
                    b.box_min = rand63();
                    b.box_max = rand63();
                    b.plane_normal = rand48();
                    b.plane_offset = $urandom();
                    b.corner_point = rand63();
                    b.axis_first = rand48();
                    b.axis_second = rand48();
                    b.axis_third = rand48();
                    send_beat(b);
                end
            end
            drain();
        end
    endtask

    initial begin
        for (int i = 0; i < PLANES; i++) begin
            pred_normal[i] = '0;
            pred_offset[i] = '0;
        end
        for (int i = 0; i < NUM_CORNERS; i++) pred_corner[i] = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random();
        if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
            $display("oriented_box_frustum_cull_tb passed");
        end else begin
            $display("oriented_box_frustum_cull_tb failed");
        end
        $finish;
    end

endmodule
